FILE: sv/rmfr_pkg.sv
// Shared constants and types of the register mirror frame receiver.
// Used by the parser, the mirror and the top level; depends on nothing.
package rmfr_pkg;

	localparam int REG_COUNT = 32;
	localparam int IDX_W     = $clog2(REG_COUNT);

	localparam logic [2:0] KIND_UPDATE = 3'd0;
	localparam logic [2:0] KIND_CHAR   = 3'd1;
	localparam logic [2:0] KIND_EMPTY  = 3'd2;
	localparam logic [2:0] KIND_BAD    = 3'd3;
	localparam logic [2:0] KIND_READ   = 3'd4;

	typedef struct packed {
		logic [2:0]  kind;
		logic [4:0]  reg_addr;
		logic [15:0] value;
		logic        last;
	} result_t;

	typedef struct packed {
		logic        en;
		logic [4:0]  addr;
		logic [15:0] data;
	} mirror_wr_t;

endpackage

FILE: sv/rmfr_in_if.sv
// Input channel of the register mirror frame receiver: received bytes and read commands.
// Stands alone; carries valid, ready and the input word.
interface rmfr_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] rx_byte;
	logic [4:0] query_addr;

	modport source (output valid, output cmd, output rx_byte, output query_addr, input ready);
	modport sink (input valid, input cmd, input rx_byte, input query_addr, output ready);
endinterface

FILE: sv/rmfr_out_if.sv
// Result channel of the register mirror frame receiver.
// Stands alone; carries valid, ready and the result word.
interface rmfr_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [4:0]  reg_addr;
	logic [15:0] value;
	logic        last;

	modport source (output valid, output kind, output reg_addr, output value, output last,
		input ready);
	modport sink (input valid, input kind, input reg_addr, input value, input last,
		output ready);
endinterface

FILE: sv/rmfr_mirror.sv
// Register mirror: REG_COUNT 16-bit registers, cleared at reset, one write and one read port.
// Depends on rmfr_pkg.
module rmfr_mirror (
	input  logic                clk,
	input  logic                arst_n,
	input  rmfr_pkg::mirror_wr_t wr,
	input  logic [4:0]          rd_addr,
	output logic [15:0]         rd_data
);

	logic [15:0] mem_q [rmfr_pkg::REG_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rmfr_pkg::REG_COUNT; i++) begin
				mem_q[i] <= 16'd0;
			end
		end else if (wr.en && (int'(wr.addr) < rmfr_pkg::REG_COUNT)) begin
			mem_q[wr.addr[rmfr_pkg::IDX_W-1:0]] <= wr.data;
		end
	end

	always_comb begin
		if (int'(rd_addr) < rmfr_pkg::REG_COUNT) begin
			rd_data = mem_q[rd_addr[rmfr_pkg::IDX_W-1:0]];
		end else begin
			rd_data = 16'd0;
		end
	end

endmodule

FILE: sv/rmfr_parser.sv
// Frame parser: decodes one input word per cycle into a mirror write and at most one result.
// Stalls while accept is low. Depends on rmfr_pkg; mirror read data comes from rmfr_mirror.
module rmfr_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic                 cmd,
	input  logic [7:0]           rx_byte,
	input  logic [4:0]           query_addr,
	input  logic [15:0]          rd_data,
	output logic [4:0]           rd_addr,
	output rmfr_pkg::mirror_wr_t wr,
	output rmfr_pkg::result_t    res,
	output logic                 res_valid
);

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_LOW    = 2'd1;
	localparam logic [1:0] PH_HIGH   = 2'd2;
	localparam logic [1:0] PH_STRING = 2'd3;

	logic [1:0] phase_q, phase_d;
	logic [4:0] pend_addr_q, pend_addr_d;
	logic [7:0] pend_low_q, pend_low_d;
	logic [6:0] str_len_q, str_len_d;
	logic [6:0] str_cnt_q, str_cnt_d;
	logic [6:0] cnt_next;

	assign rd_addr  = query_addr;
	assign cnt_next = str_cnt_q + 7'd1;

	always_comb begin
		phase_d     = phase_q;
		pend_addr_d = pend_addr_q;
		pend_low_d  = pend_low_q;
		str_len_d   = str_len_q;
		str_cnt_d   = str_cnt_q;
		wr          = '0;
		res         = '0;
		res_valid   = 1'b0;
		if (cmd) begin
			res_valid    = 1'b1;
			res.kind     = rmfr_pkg::KIND_READ;
			res.reg_addr = query_addr;
			res.value    = rd_data;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (rx_byte[7]) begin
						str_len_d = rx_byte[6:0];
						str_cnt_d = 7'd0;
						if (rx_byte[6:0] == 7'd0) begin
							res_valid = 1'b1;
							res.kind  = rmfr_pkg::KIND_EMPTY;
						end else begin
							phase_d = PH_STRING;
						end
					end else if (int'(rx_byte) >= rmfr_pkg::REG_COUNT) begin
						res_valid = 1'b1;
						res.kind  = rmfr_pkg::KIND_BAD;
						res.value = {8'd0, rx_byte};
					end else begin
						pend_addr_d = rx_byte[4:0];
						phase_d     = PH_LOW;
					end
				end
				PH_LOW: begin
					pend_low_d = rx_byte;
					phase_d    = PH_HIGH;
				end
				PH_HIGH: begin
					wr.en        = 1'b1;
					wr.addr      = pend_addr_q;
					wr.data      = {rx_byte, pend_low_q};
					phase_d      = PH_IDLE;
					res_valid    = 1'b1;
					res.kind     = rmfr_pkg::KIND_UPDATE;
					res.reg_addr = pend_addr_q;
					res.value    = {rx_byte, pend_low_q};
				end
				default: begin
					str_cnt_d = cnt_next;
					if (cnt_next == str_len_q) begin
						phase_d = PH_IDLE;
					end
					res_valid = 1'b1;
					res.kind  = rmfr_pkg::KIND_CHAR;
					res.value = {8'd0, rx_byte};
					res.last  = (cnt_next == str_len_q);
				end
			endcase
		end
		if (!accept) begin
			wr.en     = 1'b0;
			res_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			pend_addr_q <= 5'd0;
			pend_low_q  <= 8'd0;
			str_len_q   <= 7'd0;
			str_cnt_q   <= 7'd0;
		end else if (accept) begin
			phase_q     <= phase_d;
			pend_addr_q <= pend_addr_d;
			pend_low_q  <= pend_low_d;
			str_len_q   <= str_len_d;
			str_cnt_q   <= str_cnt_d;
		end
	end

endmodule

FILE: sv/register_mirror_frame_receiver.sv
// Top level of the register mirror frame receiver: parser, mirror and result buffering.
// Depends on rmfr_pkg, rmfr_in_if, rmfr_out_if, rmfr_parser and rmfr_mirror.
//
// The link channel takes one word per cycle: with cmd low it carries a received byte
// for the frame parser, with cmd high it asks for the mirror entry at query_addr.
// Register update frames (address, low byte, high byte) write the 32-entry mirror and
// report the new value; string frames pass each character on with a last mark on the
// final one. A read is answered at once and leaves any frame in progress untouched.
// Every word is decoded in the cycle it is accepted; its result, if any, is registered
// for the report channel. Throughput is one word per cycle while link.ready is high.
// The report channel is fed from an output register backed by a one-word skid
// register, so the link keeps accepting while a result waits; link.ready falls only
// when both are full, and rises again as soon as the receiver takes a word.
// Reset clears the parser to idle, the mirror to zero and both result registers to
// empty; the block accepts words in the first cycle after reset is released.
module register_mirror_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,
	rmfr_in_if.sink     link,
	rmfr_out_if.source  report
);

	logic                 accept;
	logic                 take;
	logic [4:0]           rd_addr;
	logic [15:0]          rd_data;
	rmfr_pkg::mirror_wr_t wr;
	rmfr_pkg::result_t    res;
	logic                 res_valid;
	rmfr_pkg::result_t    out_q, skid_q;
	logic                 out_valid_q, skid_valid_q;

	assign link.ready = !skid_valid_q;
	assign accept     = link.valid && link.ready;
	assign take       = out_valid_q && report.ready;

	rmfr_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.cmd        (link.cmd),
		.rx_byte    (link.rx_byte),
		.query_addr (link.query_addr),
		.rd_data    (rd_data),
		.rd_addr    (rd_addr),
		.wr         (wr),
		.res        (res),
		.res_valid  (res_valid)
	);

	rmfr_mirror u_mirror (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || take) begin
			out_valid_q <= res_valid;
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (!out_valid_q || take) begin
			out_q <= res;
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign report.valid    = out_valid_q;
	assign report.kind     = out_q.kind;
	assign report.reg_addr = out_q.reg_addr;
	assign report.value    = out_q.value;
	assign report.last     = out_q.last;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a word while the output register is empty");

	a_read_answered: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && link.cmd && (!out_valid_q || report.ready)) |=>
		(out_valid_q && out_q.kind == rmfr_pkg::KIND_READ))
		else $error("accepted read command was not answered in the next cycle");

	a_last_on_char: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.last) |-> (out_q.kind == rmfr_pkg::KIND_CHAR))
		else $error("last mark set on a result that is not a string character");

endmodule
